// ----- sv/dsch_pkg.sv -----
// shared types and constants for the disk request scheduler
`timescale 1ns / 1ps
package dsch_pkg;

	localparam int TRACK_W = 9;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 6;
	localparam int DIST_W  = 9;
	localparam int SEEK_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [TRACK_W-1:0] TRACK_FLOOR = 9'd8;
	localparam logic [TRACK_W-1:0] RESET_TRACKS = 9'd256;
	localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;
	localparam logic [SEEK_W-1:0] SEEK_MAX = 16'hFFFF;

	// input command codes
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TRACK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_DIR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd3;

	// policy codes, unused codes act as fcfs
	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_SSTF  = 3'd1;
	localparam logic [2:0] POL_SCAN  = 3'd2;
	localparam logic [2:0] POL_CSCAN = 3'd3;
	localparam logic [2:0] POL_CLOOK = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADD_SCAN,
		ST_RUN_SCAN,
		ST_PICK,
		ST_FETCH,
		ST_OUT,
		ST_EMPTY,
		ST_CLEAR
	} dsch_state_t;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic write_entry;
		logic run_init;
		logic pick;
		logic emit;
		logic emit_empty;
		logic clear;
	} dsch_cmd_t;

	typedef struct packed {
		logic is_run;
		logic add_ok;
		logic dup;
		logic scan_done;
		logic count_zero;
		logic out_free;
		logic last_k;
		logic pick_none;
	} dsch_sts_t;

endpackage

// ----- sv/dsch_ctrl.sv -----
// controller state machine sequencing loads and schedule runs
`timescale 1ns / 1ps
module dsch_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dsch_pkg::dsch_sts_t sts,
	output dsch_pkg::dsch_cmd_t cmd
);
	import dsch_pkg::*;

	dsch_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_run) begin
					if (sts.count_zero) begin
						state_d = ST_EMPTY;
					end else begin
						cmd.run_init = 1'b1;
						cmd.scan_start = 1'b1;
						state_d = ST_RUN_SCAN;
					end
				end else if (sts.add_ok) begin
					cmd.scan_start = 1'b1;
					state_d = ST_ADD_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD_SCAN: begin
				if (sts.scan_done) begin
					cmd.write_entry = !sts.dup;
					state_d = ST_IDLE;
				end
			end
			ST_RUN_SCAN: begin
				if (sts.scan_done) state_d = ST_PICK;
			end
			ST_PICK: begin
				if (sts.pick_none) begin
					state_d = ST_CLEAR;
				end else begin
					cmd.pick = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_k) begin
						state_d = ST_CLEAR;
					end else begin
						cmd.scan_start = 1'b1;
						state_d = ST_RUN_SCAN;
					end
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- sv/dsch_dp.sv -----
// datapath: request table, scan compare, pick arithmetic, config and output registers
`timescale 1ns / 1ps
module dsch_dp #(
	parameter int MAX_REQUESTS = 64,
	parameter int TRACK_LIMIT  = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [23:0]                       s_tdata,
	input  logic                              s_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dsch_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsch_pkg::TRACK_W-1:0]      cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	input  dsch_pkg::dsch_cmd_t               cmd,
	output dsch_pkg::dsch_sts_t               sts
);
	import dsch_pkg::*;

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);
	localparam logic [TRACK_W-1:0] LIMIT = TRACK_W'(TRACK_LIMIT);
	localparam int EW = TRACK_W + BYTE_W;

	typedef struct packed {
		logic              vld;
		logic [IW-1:0]     idx;
		logic [TRACK_W-1:0] trk;
	} cand_t;

	// configuration
	logic [TRACK_W-1:0] track_count_q, start_track_q;
	logic               start_dir_q;
	logic [2:0]         policy_q;
	logic [TRACK_W-1:0] tc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= RESET_TRACKS;
			start_track_q <= '0;
			start_dir_q   <= 1'b0;
			policy_q      <= POL_FCFS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRACK_COUNT: track_count_q <= cfg_data;
				REG_START_TRACK: start_track_q <= cfg_data;
				REG_START_DIR:   start_dir_q   <= cfg_data[0];
				REG_POLICY:      policy_q      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (track_count_q < TRACK_FLOOR) tc = TRACK_FLOOR;
		else if (track_count_q > LIMIT) tc = LIMIT;
		else tc = track_count_q;
	end

	// captured request
	logic               cmd_q;
	logic [TRACK_W-1:0] trk_in_q;
	logic [BYTE_W-1:0]  byte_in_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= s_tuser;
			trk_in_q  <= s_tdata[8:0];
			byte_in_q <= s_tdata[16:9];
		end
	end

	// table storage, track in the upper bits
	logic [EW-1:0]       mem [MAX_REQUESTS];
	logic [EW-1:0]       rd_data_s1;
	logic [IW-1:0]       rd_addr;
	logic [MAX_REQUESTS-1:0] pending_q;
	logic [CW-1:0]       count_q, k_q, ptr_q;
	logic                scan_act_q, vld_s1;
	logic [IW-1:0]       idx_s1;
	logic [IW-1:0]       sel_idx_q;

	assign rd_addr = scan_act_q ? ptr_q[IW-1:0] : sel_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.write_entry) mem[count_q[IW-1:0]] <= {trk_in_q, byte_in_q};
		rd_data_s1 <= mem[rd_addr];
	end

	// scan address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			vld_s1     <= 1'b0;
			ptr_q      <= '0;
			idx_s1     <= '0;
		end else if (cmd.scan_start) begin
			scan_act_q <= 1'b1;
			vld_s1     <= 1'b0;
			ptr_q      <= '0;
		end else if (scan_act_q) begin
			if (ptr_q < count_q) begin
				vld_s1 <= 1'b1;
				idx_s1 <= ptr_q[IW-1:0];
				ptr_q  <= ptr_q + 1'b1;
			end else begin
				scan_act_q <= 1'b0;
				vld_s1     <= 1'b0;
			end
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	// run state
	logic [TRACK_W-1:0] head_q;
	logic               dir_q;
	logic [SEEK_W-1:0]  seek_q;

	// scan compare
	cand_t              first_q, near_q, ge_q, le_q, min_q, max_q;
	logic [TRACK_W-1:0] near_d_q;
	logic               dup_q;
	logic [TRACK_W-1:0] e_trk, e_dist;
	logic               e_pend;

	assign e_trk  = rd_data_s1[EW-1:BYTE_W];
	assign e_pend = vld_s1 && pending_q[idx_s1];
	assign e_dist = (e_trk >= head_q) ? e_trk - head_q : head_q - e_trk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			near_q  <= '0;
			ge_q    <= '0;
			le_q    <= '0;
			min_q   <= '0;
			max_q   <= '0;
			dup_q   <= 1'b0;
			near_d_q <= '0;
		end else if (cmd.scan_start) begin
			first_q.vld <= 1'b0;
			near_q.vld  <= 1'b0;
			ge_q.vld    <= 1'b0;
			le_q.vld    <= 1'b0;
			min_q.vld   <= 1'b0;
			max_q.vld   <= 1'b0;
			dup_q       <= 1'b0;
		end else if (e_pend) begin
			if (cmd_q == CMD_ADD) begin
				if (e_trk == trk_in_q) dup_q <= 1'b1;
			end else begin
				if (!first_q.vld) first_q <= '{1'b1, idx_s1, e_trk};
				// strict compare keeps the lowest index on a tie
				if (!near_q.vld || e_dist < near_d_q) begin
					near_q   <= '{1'b1, idx_s1, e_trk};
					near_d_q <= e_dist;
				end
				if (e_trk >= head_q && (!ge_q.vld || e_trk < ge_q.trk))
					ge_q <= '{1'b1, idx_s1, e_trk};
				if (e_trk <= head_q && (!le_q.vld || e_trk > le_q.trk))
					le_q <= '{1'b1, idx_s1, e_trk};
				if (!min_q.vld || e_trk < min_q.trk) min_q <= '{1'b1, idx_s1, e_trk};
				if (!max_q.vld || e_trk > max_q.trk) max_q <= '{1'b1, idx_s1, e_trk};
			end
		end
	end

	// pick the next request and its charged distance
	cand_t        sel;
	logic [10:0]  mv_dist, h11, hi11, lo11, top11;
	logic         dir_n;
	logic [DIST_W-1:0] dist_sat;
	logic [SEEK_W:0]   seek_sum;
	logic [SEEK_W-1:0] seek_n;

	always_comb begin
		h11   = {2'b0, head_q};
		hi11  = (tc > head_q) ? {2'b0, tc} : h11;
		lo11  = (head_q == '0) ? 11'd0 : 11'd1;
		top11 = (tc > max_q.trk) ? {2'b0, tc} : {2'b0, max_q.trk};
		sel     = first_q;
		mv_dist = '0;
		dir_n   = dir_q;
		case (policy_q)
			POL_SSTF: begin
				sel     = near_q;
				mv_dist = {2'b0, near_d_q};
			end
			POL_SCAN, POL_CSCAN, POL_CLOOK: begin
				if (!dir_q) begin
					if (ge_q.vld) begin
						sel     = ge_q;
						mv_dist = {2'b0, ge_q.trk} - h11;
					end else if (policy_q == POL_SCAN) begin
						sel     = le_q;
						mv_dist = (hi11 - h11) + (hi11 - {2'b0, le_q.trk});
						dir_n   = 1'b1;
					end else begin
						sel = min_q;
						if (policy_q == POL_CSCAN)
							mv_dist = (hi11 - h11) + ({2'b0, min_q.trk} - 11'd1);
					end
				end else begin
					if (le_q.vld) begin
						sel     = le_q;
						mv_dist = h11 - {2'b0, le_q.trk};
					end else if (policy_q == POL_SCAN) begin
						sel     = ge_q;
						mv_dist = (h11 - lo11) + ({2'b0, ge_q.trk} - lo11);
						dir_n   = 1'b0;
					end else begin
						sel = max_q;
						if (policy_q == POL_CSCAN)
							mv_dist = (h11 - lo11) + (top11 - {2'b0, max_q.trk});
					end
				end
			end
			default: begin
				mv_dist = (first_q.trk >= head_q) ? {2'b0, first_q.trk - head_q}
					: {2'b0, head_q - first_q.trk};
			end
		endcase
		dist_sat = (mv_dist > {2'b0, DIST_MAX}) ? DIST_MAX : mv_dist[DIST_W-1:0];
		seek_sum = {1'b0, seek_q} + {{(SEEK_W-DIST_W+1){1'b0}}, dist_sat};
		seek_n   = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];
	end

	logic [TRACK_W-1:0] sel_trk_q;
	logic [DIST_W-1:0]  dist_q;

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			sel_trk_q <= sel.trk;
			dist_q    <= dist_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
			k_q       <= '0;
			head_q    <= '0;
			dir_q     <= 1'b0;
			seek_q    <= '0;
			sel_idx_q <= '0;
		end else begin
			if (cmd.clear) begin
				pending_q <= '0;
				count_q   <= '0;
			end else if (cmd.write_entry) begin
				pending_q[count_q[IW-1:0]] <= 1'b1;
				count_q <= count_q + 1'b1;
			end else if (cmd.pick) begin
				pending_q[sel.idx] <= 1'b0;
			end
			if (cmd.run_init) begin
				head_q <= (start_track_q > tc) ? tc : start_track_q;
				dir_q  <= start_dir_q;
				seek_q <= '0;
				k_q    <= '0;
			end else if (cmd.pick) begin
				head_q    <= sel.trk;
				dir_q     <= dir_n;
				seek_q    <= seek_n;
				sel_idx_q <= sel.idx;
			end else if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// output register
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_empty) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= {seek_q, dist_q, INDEX_W'(sel_idx_q), rd_data_s1[BYTE_W-1:0],
				sel_trk_q};
			m_tuser <= 1'b0;
			m_tlast <= (k_q + 1'b1 == count_q);
		end else if (cmd.emit_empty) begin
			m_tdata <= '0;
			m_tuser <= 1'b1;
			m_tlast <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;

	assign sts.is_run     = (cmd_q == CMD_RUN);
	assign sts.add_ok     = (trk_in_q != '0) && (trk_in_q <= tc) && (count_q < MAX_CNT);
	assign sts.dup        = dup_q;
	assign sts.scan_done  = !scan_act_q && !vld_s1;
	assign sts.count_zero = (count_q == '0);
	assign sts.out_free   = !out_vld_q || m_tready;
	assign sts.last_k     = (k_q + 1'b1 == count_q);
	assign sts.pick_none  = !sel.vld;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT) else $error("request count above table depth");
	a_pending_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pending_q) <= int'(count_q)) else $error("pending flags exceed count");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_empty) |-> (!out_vld_q || m_tready))
		else $error("result written over a waiting result");
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !scan_act_q && !vld_s1) else $error("scan restarted while busy");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |=> $past(count_q) < MAX_CNT) else $error("write into full table");

endmodule

// ----- sv/disk_request_scheduler.sv -----
// Disk request scheduler top level.
// Input stream s_*: tuser is the command (0 add a request, 1 run the schedule).
// An add stores the track and byte unless the track is 0, above the effective
// track count, already pending, or the table is full; it yields no result.
// A run emits one result per pending request in service order under the
// selected policy, then clears the table; an empty run emits one result with
// tuser (none_pending) and tlast set.
// Config channel cfg_*: index 0 track_count, 1 start_track, 2 start_direction,
// 3 policy; always ready; write it only while the block is idle, as the block does not enforce this.
// An add's duration is set by the duplicate check walking the table one entry per
// cycle over its single read port. Each run result takes a table walk to find
// the candidates, a pick step, a data fetch and the output load.
// One request is handled at a time; s_tready is high only between requests.
// Results sit in an output register, and the next walk proceeds while one
// waits; a stalled receiver holds the block at the next output load.
// Reset clears the table, the run state and the registers to their defaults.
`timescale 1ns / 1ps
module disk_request_scheduler #(
	parameter int MAX_REQUESTS = 64,
	parameter int TRACK_LIMIT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // request_track, data_byte, zero pad
	input  logic        s_tuser,    // command
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dsch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsch_pkg::TRACK_W-1:0]   cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // served_track, served_byte, request_index, move_distance, total_seek
	output logic        m_tuser,    // none_pending
	output logic        m_tlast
);
	import dsch_pkg::*;

	dsch_cmd_t cmd;
	dsch_sts_t sts;

	dsch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsch_dp #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.TRACK_LIMIT  (TRACK_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- bench/tb.sv -----
// testbench for the disk request scheduler: predicted service order checked per result
`timescale 1ns / 1ps
module tb;
	import dsch_pkg::*;

	typedef struct packed {
		logic       cmd;
		logic [8:0] trk;
		logic [7:0] byt;
	} req_t;

	typedef struct packed {
		logic [8:0]  trk;
		logic [7:0]  byt;
		logic [5:0]  idx;
		logic [8:0]  mdist;
		logic [15:0] seek;
		logic        none;
		logic        lst;
	} svc_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [23:0] s_tdata = '0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TRACK_W-1:0] cfg_data = '0;
	logic m_tvalid, m_tready = 0, m_tuser, m_tlast;
	logic [47:0] m_tdata;

	disk_request_scheduler dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [8:0] m_count = 9'd256, m_start = 9'd0;
	logic       m_dir = 0;
	logic [2:0] m_pol = 0;
	logic [8:0] tbl_trk [64];
	logic [7:0] tbl_byt [64];
	bit         tbl_pend [64];
	int         tbl_n = 0;

	req_t pending_reqs[$];
	svc_t expected_svc[$];
	int   errors = 0, n_results = 0, n_runs = 0;
	int   send_idle = 36, recv_idle = 56;
	int   hold_cycles = 0;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("tb: mismatch %s got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int find_ge(int h);
		int b = -1;
		for (int i = 0; i < 64; i++)
			if (tbl_pend[i] && tbl_trk[i] >= h && (b < 0 || tbl_trk[i] < tbl_trk[b])) b = i;
		return b;
	endfunction

	function automatic int find_le(int h);
		int b = -1;
		for (int i = 0; i < 64; i++)
			if (tbl_pend[i] && tbl_trk[i] <= h && (b < 0 || tbl_trk[i] > tbl_trk[b])) b = i;
		return b;
	endfunction

	function automatic int adiff(int a, int b);
		return a > b ? a - b : b - a;
	endfunction

	task automatic predict_service(req_t r);
		int tc, h, hi, lo, mv, idx, total, cnt, t, top;
		logic dir;
		svc_t s;
		tc = m_count < 8 ? 8 : (m_count > 256 ? 256 : m_count);
		if (r.cmd == CMD_ADD) begin
			if (r.trk == 0 || r.trk > tc || tbl_n >= 64) return;
			for (int i = 0; i < 64; i++) if (tbl_pend[i] && tbl_trk[i] == r.trk) return;
			tbl_trk[tbl_n] = r.trk; tbl_byt[tbl_n] = r.byt; tbl_pend[tbl_n] = 1;
			tbl_n++;
			return;
		end
		n_runs++;
		if (tbl_n == 0) begin
			s = '0; s.none = 1; s.lst = 1;
			expected_svc.push_back(s);
			return;
		end
		h = m_start > tc ? tc : m_start;
		dir = m_dir; total = 0; cnt = tbl_n;
		for (int k = 0; k < cnt; k++) begin
			hi = tc > h ? tc : h;
			lo = h < 1 ? h : 1;
			mv = 0;
			if (m_pol == POL_SSTF) begin
				idx = -1;
				for (int i = 0; i < 64; i++)
					if (tbl_pend[i] && (idx < 0 || adiff(tbl_trk[i], h) < adiff(tbl_trk[idx], h)))
						idx = i;
				if (idx >= 0) mv = adiff(tbl_trk[idx], h);
			end else if (m_pol >= POL_SCAN && m_pol <= POL_CLOOK) begin
				idx = dir == 0 ? find_ge(h) : find_le(h);
				if (idx >= 0) mv = adiff(tbl_trk[idx], h);
				else if (dir == 0) begin
					if (m_pol == POL_SCAN) begin
						idx = find_le(h);
						if (idx >= 0) mv = (hi - h) + (hi - tbl_trk[idx]);
						dir = 1;
					end else begin
						idx = find_ge(0);
						if (idx >= 0 && m_pol == POL_CSCAN) mv = (hi - h) + (tbl_trk[idx] - 1);
					end
				end else begin
					if (m_pol == POL_SCAN) begin
						idx = find_ge(h);
						if (idx >= 0) mv = (h - lo) + (tbl_trk[idx] - lo);
						dir = 0;
					end else begin
						idx = find_le(1000);
						if (idx >= 0 && m_pol == POL_CSCAN) begin
							t = tbl_trk[idx];
							top = tc > t ? tc : t;
							mv = (h - lo) + (top - t);
						end
					end
				end
			end else begin
				idx = -1;
				for (int i = 63; i >= 0; i--) if (tbl_pend[i]) idx = i;
				if (idx >= 0) mv = adiff(tbl_trk[idx], h);
			end
			if (idx < 0) break;
			if (mv > 511) mv = 511;
			total += mv;
			if (total > 65535) total = 65535;
			h = tbl_trk[idx];
			tbl_pend[idx] = 0;
			s.trk = tbl_trk[idx]; s.byt = tbl_byt[idx]; s.idx = 6'(idx);
			s.mdist = 9'(mv); s.seek = 16'(total); s.none = 0; s.lst = (k + 1 == cnt);
			expected_svc.push_back(s);
		end
		for (int i = 0; i < 64; i++) tbl_pend[i] = 0;
		tbl_n = 0;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_service(pending_reqs.pop_front());
			if (!(s_tvalid && !s_tready)) begin
				if (pending_reqs.size() > (s_tvalid && s_tready ? 0 : 0) &&
				    $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1;
					s_tuser <= pending_reqs[0].cmd;
					s_tdata <= {7'd0, pending_reqs[0].byt, pending_reqs[0].trk};
				end else
					s_tvalid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		svc_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_svc.size() == 0) report("unexpected result", 64'(m_tdata), 64'd0);
				else begin
					e = expected_svc.pop_front();
					if (m_tdata[8:0] != e.trk)
						report("served_track", 64'(m_tdata[8:0]), 64'(e.trk));
					if (m_tdata[16:9] != e.byt)
						report("served_byte", 64'(m_tdata[16:9]), 64'(e.byt));
					if (m_tdata[22:17] != e.idx)
						report("request_index", 64'(m_tdata[22:17]), 64'(e.idx));
					if (m_tdata[31:23] != e.mdist)
						report("move_distance", 64'(m_tdata[31:23]), 64'(e.mdist));
					if (m_tdata[47:32] != e.seek)
						report("total_seek", 64'(m_tdata[47:32]), 64'(e.seek));
					if (m_tuser != e.none) report("none_pending", 64'(m_tuser), 64'(e.none));
					if (m_tlast != e.lst) report("last", 64'(m_tlast), 64'(e.lst));
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 0;
			end else
				m_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_TRACK_COUNT: m_count = val;
			REG_START_TRACK: m_start = val;
			REG_START_DIR:   m_dir = val[0];
			default:         m_pol = val[2:0];
		endcase
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || s_tvalid || expected_svc.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic req_t mk(logic c, logic [8:0] t, logic [7:0] b);
		req_t r;
		r.cmd = c; r.trk = t; r.byt = b;
		return r;
	endfunction

	// one batch of adds then a run
	task automatic queue_batch(int n, int tmax);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(mk(CMD_ADD, 9'($urandom_range(tmax, 0)), 8'($urandom)));
		pending_reqs.push_back(mk(CMD_RUN, 9'($urandom), 8'($urandom)));
	endtask

	initial begin
		int sent;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// directed: empty run, extremes, duplicate, invalid tracks
		pending_reqs.push_back(mk(CMD_RUN, 9'd0, 8'd0));
		pending_reqs.push_back(mk(CMD_ADD, 9'd256, 8'hff));
		pending_reqs.push_back(mk(CMD_ADD, 9'd1, 8'h00));
		pending_reqs.push_back(mk(CMD_ADD, 9'd256, 8'h55));
		pending_reqs.push_back(mk(CMD_ADD, 9'd0, 8'h11));
		pending_reqs.push_back(mk(CMD_ADD, 9'h1ff, 8'haa));
		pending_reqs.push_back(mk(CMD_ADD, 9'd128, 8'h5a));
		pending_reqs.push_back(mk(CMD_RUN, 9'h1ff, 8'hff));
		drain();
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_POLICY, 9'(p));
			write_reg(REG_START_DIR, 9'(p[0]));
			write_reg(REG_START_TRACK, 9'(p * 40));
			queue_batch(3, 256);
			drain();
		end
		// table full: 66 distinct adds
		for (int i = 1; i <= 66; i++) pending_reqs.push_back(mk(CMD_ADD, 9'(i), 8'(i)));
		pending_reqs.push_back(mk(CMD_RUN, 9'd0, 8'd0));
		drain();
		// track count lowered after loading, then clamp of small values
		write_reg(REG_POLICY, 9'(POL_SCAN));
		pending_reqs.push_back(mk(CMD_ADD, 9'd200, 8'd1));
		pending_reqs.push_back(mk(CMD_ADD, 9'd20, 8'd2));
		drain();
		write_reg(REG_TRACK_COUNT, 9'd3);
		write_reg(REG_START_TRACK, 9'h1ff);
		pending_reqs.push_back(mk(CMD_ADD, 9'd5, 8'd3));
		pending_reqs.push_back(mk(CMD_RUN, 9'd0, 8'd0));
		drain();
		// random phases
		sent = 0;
		for (int ph = 0; ph < 24; ph++) begin
			if (ph == 8) begin send_idle = 56; recv_idle = 36; end
			if (ph == 16) begin send_idle = 0; recv_idle = 0; end
			write_reg(REG_TRACK_COUNT,
				9'(ph % 6 == 0 ? 256 : (ph % 6 == 1 ? 8 : $urandom_range(300, 0))));
			write_reg(REG_START_TRACK, 9'(ph % 5 == 0 ? 256 : $urandom_range(260, 0)));
			write_reg(REG_START_DIR, 9'($urandom));
			write_reg(REG_POLICY, 9'($urandom));
			if (ph == 5) hold_cycles = 2000;
			while (sent < (ph + 1) * 15) begin
				int n;
				n = $urandom_range(12, 0);
				if ($urandom_range(9) == 0)
					pending_reqs.push_back(mk(1'($urandom), 9'($urandom), 8'($urandom)));
				queue_batch(n, m_count < 8 ? 8 : (m_count > 256 ? 256 : m_count + 4));
				sent += n + 1;
			end
			drain();
		end
		$display("tb: %0d runs and %0d results checked over all five policies", n_runs, n_results);
		$display("tb: track counts and start tracks swept, table full and duplicates included");
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/dsch_pkg.sv
sv/dsch_ctrl.sv
sv/dsch_dp.sv
sv/disk_request_scheduler.sv
bench/tb.sv
